@@ hw/rtl/ldsp_pkg.sv @@
// Shared types, codes and constants of the LED dimmer switch panel.
package ldsp_pkg;

  localparam int unsigned SW_W      = 8;
  localparam int unsigned LED_W     = 8;
  localparam int unsigned SEL_W     = 3;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned NPHASE    = 4;
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Command queue between front and back
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;
  localparam int unsigned QCNT_W  = 2;

  // Reset values of the hold registers
  localparam logic [HOLD_W-1:0] BLINK_HOLD_RST = 16'd1000;
  localparam logic [HOLD_W-1:0] PRESS_HOLD_RST = 16'd10000;
  localparam logic [HOLD_W-1:0] FRAME_HOLD_RST = 16'd25;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HOLD = 2'd2;

  // Switch commands; codes below CMD_BLINK set the PWM level
  localparam logic [CMD_W-1:0] CMD_LEVEL_MAX = 3'd4;
  localparam logic [CMD_W-1:0] CMD_BLINK     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DOWN      = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UP        = 3'd7;

  // Result steps of one pass, in emission order
  typedef enum logic [2:0] {
    STEP_BLINK_ON0,
    STEP_BLINK_OFF0,
    STEP_BLINK_ON1,
    STEP_BLINK_OFF1,
    STEP_PAUSE,
    STEP_FRAME
  } step_t;

  // One classified pass, handed from front to back
  typedef struct packed {
    logic             blink;
    logic             press;
    logic [LED_W-1:0] sel_bit;
    logic [LED_W-1:0] pause_pat;
    logic [LED_W-1:0] frame_pat;
  } job_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Hold lengths from the configuration registers
  typedef struct packed {
    logic [HOLD_W-1:0] blink_hold;
    logic [HOLD_W-1:0] press_hold;
    logic [HOLD_W-1:0] frame_hold;
  } holds_t;

endpackage

@@ hw/rtl/ldsp_front.sv @@
// Front: decodes each scan pass, updates panel state and builds one job.
module ldsp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [ldsp_pkg::SW_W-1:0]   switch_bits,
  output ldsp_pkg::job_t              job
);

  logic [ldsp_pkg::LED_W-1:0]   phase_masks_r [ldsp_pkg::NPHASE];
  logic [ldsp_pkg::LED_W-1:0]   phase_masks_nxt [ldsp_pkg::NPHASE];
  logic [ldsp_pkg::PHASE_W-1:0] phase_index_r;
  logic [ldsp_pkg::SEL_W-1:0]   chosen_led_r, chosen_led_nxt;
  logic [ldsp_pkg::LED_W-1:0]   shown_r;

  logic                         pressed;
  logic [ldsp_pkg::CMD_W-1:0]   cmd;
  logic [ldsp_pkg::LED_W-1:0]   sel_bit;

  // Recognize a press: exactly one switch set, its index is the command
  always_comb begin
    pressed = (switch_bits != '0) &&
              ((switch_bits & (switch_bits - ldsp_pkg::SW_W'(1))) == '0);
    cmd = '0;
    for (int n = 0; n < ldsp_pkg::SW_W; n++) begin
      if (switch_bits[n]) begin
        cmd = ldsp_pkg::CMD_W'(n);
      end
    end
  end

  assign sel_bit = ldsp_pkg::LED_W'(1) << chosen_led_r;

  // Apply the command to the phase masks and the selection
  always_comb begin
    chosen_led_nxt = chosen_led_r;
    for (int p = 0; p < ldsp_pkg::NPHASE; p++) begin
      phase_masks_nxt[p] = phase_masks_r[p];
    end
    if (pressed) begin
      if (cmd <= ldsp_pkg::CMD_LEVEL_MAX) begin
        for (int p = 0; p < ldsp_pkg::NPHASE; p++) begin
          if ((ldsp_pkg::CMD_W'(p) + cmd) < ldsp_pkg::CMD_W'(ldsp_pkg::NPHASE)) begin
            phase_masks_nxt[p] = phase_masks_r[p] | sel_bit;
          end else begin
            phase_masks_nxt[p] = phase_masks_r[p] & ~sel_bit;
          end
        end
      end else if (cmd == ldsp_pkg::CMD_DOWN) begin
        chosen_led_nxt = chosen_led_r - ldsp_pkg::SEL_W'(1);
      end else if (cmd == ldsp_pkg::CMD_UP) begin
        chosen_led_nxt = chosen_led_r + ldsp_pkg::SEL_W'(1);
      end
    end
  end

  // Build the job; a pause after a blink shows all LEDs dark
  always_comb begin
    job.press     = pressed;
    job.blink     = pressed && (cmd == ldsp_pkg::CMD_BLINK);
    job.sel_bit   = sel_bit;
    job.pause_pat = job.blink ? '0 : shown_r;
    job.frame_pat = phase_masks_nxt[phase_index_r];
  end

  // Hold state between passes; the frame ends every pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < ldsp_pkg::NPHASE; p++) begin
        phase_masks_r[p] <= '0;
      end
      phase_index_r <= '0;
      chosen_led_r  <= '0;
      shown_r       <= '0;
    end else if (accept) begin
      for (int p = 0; p < ldsp_pkg::NPHASE; p++) begin
        phase_masks_r[p] <= phase_masks_nxt[p];
      end
      phase_index_r <= phase_index_r + ldsp_pkg::PHASE_W'(1);
      chosen_led_r  <= chosen_led_nxt;
      shown_r       <= phase_masks_nxt[phase_index_r];
    end
  end

endmodule

@@ hw/rtl/ldsp_queue.sv @@
// Two-entry job queue between the front and the back.
module ldsp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  ldsp_pkg::job_t    wr_job,
  input  logic              rd_en,
  output ldsp_pkg::job_t    rd_job,
  output ldsp_pkg::q_stat_t stat
);

  ldsp_pkg::job_t                  slot_r [ldsp_pkg::QDEPTH];
  logic [ldsp_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [ldsp_pkg::QCNT_W-1:0]     count_r;

  assign stat.full  = (count_r == ldsp_pkg::QCNT_W'(ldsp_pkg::QDEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_job     = slot_r[rd_ptr_r];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + ldsp_pkg::QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + ldsp_pkg::QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + ldsp_pkg::QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - ldsp_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/ldsp_back.sv @@
// Back: steps through the results of each job into the output register.
module ldsp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ldsp_pkg::job_t                job,
  input  logic                          job_valid,
  input  ldsp_pkg::holds_t              holds,
  output logic                          job_done,
  output logic                          emit,
  output logic                          out_valid,
  input  logic                          out_take,
  output logic [ldsp_pkg::LED_W-1:0]    led_pattern,
  output logic [ldsp_pkg::HOLD_W-1:0]   hold_units,
  output logic                          last_of_pass
);

  ldsp_pkg::step_t                step_r, step_nxt, cur_step, first_step;
  logic                           started_r, started_nxt;
  logic                           out_valid_r;
  logic [ldsp_pkg::LED_W-1:0]     pat_r;
  logic [ldsp_pkg::HOLD_W-1:0]    hold_r;
  logic                           last_r;
  logic [ldsp_pkg::LED_W-1:0]     pat;
  logic [ldsp_pkg::HOLD_W-1:0]    hold;

  // Pick the first step of a fresh job
  always_comb begin
    priority if (job.blink) begin
      first_step = ldsp_pkg::STEP_BLINK_ON0;
    end else if (job.press) begin
      first_step = ldsp_pkg::STEP_PAUSE;
    end else begin
      first_step = ldsp_pkg::STEP_FRAME;
    end
  end

  assign cur_step = started_r ? step_r : first_step;
  assign emit     = job_valid && (!out_valid_r || out_take);
  assign job_done = emit && (cur_step == ldsp_pkg::STEP_FRAME);

  // Select pattern and hold for the current step
  always_comb begin
    unique case (cur_step)
      ldsp_pkg::STEP_BLINK_ON0,
      ldsp_pkg::STEP_BLINK_ON1: begin
        pat  = job.sel_bit;
        hold = holds.blink_hold;
      end
      ldsp_pkg::STEP_BLINK_OFF0,
      ldsp_pkg::STEP_BLINK_OFF1: begin
        pat  = '0;
        hold = holds.blink_hold;
      end
      ldsp_pkg::STEP_PAUSE: begin
        pat  = job.pause_pat;
        hold = holds.press_hold;
      end
      ldsp_pkg::STEP_FRAME: begin
        pat  = job.frame_pat;
        hold = holds.frame_hold;
      end
      default: begin
        pat  = '0;
        hold = '0;
      end
    endcase
  end

  // Advance the step sequencer
  always_comb begin
    step_nxt    = step_r;
    started_nxt = started_r;
    if (emit) begin
      if (job_done) begin
        started_nxt = 1'b0;
      end else begin
        step_nxt    = ldsp_pkg::step_t'(cur_step + 3'd1);
        started_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ldsp_pkg::STEP_FRAME;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r    <= step_nxt;
      started_r <= started_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (emit) begin
      pat_r  <= pat;
      hold_r <= hold;
      last_r <= (cur_step == ldsp_pkg::STEP_FRAME);
    end
  end

  assign out_valid    = out_valid_r;
  assign led_pattern  = pat_r;
  assign hold_units   = hold_r;
  assign last_of_pass = last_r;

endmodule

@@ hw/rtl/led_dimmer_switch_panel.sv @@
// Top level of the LED dimmer switch panel: config, front, queue, back.
// A taken pass is written into the job queue; its results go to the output register.
// Throughput: one result per cycle from the back while the output is empty or popped;
// a pass gives 1, 2 or 6 results (frame only, press, blink press); the front takes
// a pass per cycle while the two-entry job queue has room.
// Reset (rst_n, synchronous): all LEDs off in every phase, phase 0, LED 0 selected,
// queue and output empty, hold registers 1000 / 10000 / 25.
module led_dimmer_switch_panel (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [ldsp_pkg::SW_W-1:0]         in_switch_bits,
  output logic                              empty,
  input  logic                              pop,
  output logic [ldsp_pkg::LED_W-1:0]        out_led_pattern,
  output logic [ldsp_pkg::HOLD_W-1:0]       out_hold_units,
  output logic                              out_last_of_pass,
  input  logic                              cfg_we,
  input  logic [ldsp_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [ldsp_pkg::HOLD_W-1:0]       cfg_wdata
);

  ldsp_pkg::holds_t  holds_r;
  ldsp_pkg::job_t    front_job, head_job;
  ldsp_pkg::q_stat_t q_stat;
  logic              in_accept;
  logic              job_done;
  logic              emit;
  logic              out_valid;
  logic              out_take;

  // Write configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holds_r.blink_hold <= ldsp_pkg::BLINK_HOLD_RST;
      holds_r.press_hold <= ldsp_pkg::PRESS_HOLD_RST;
      holds_r.frame_hold <= ldsp_pkg::FRAME_HOLD_RST;
    end else if (cfg_we) begin
      if (cfg_addr == ldsp_pkg::CFG_BLINK_HOLD) begin
        holds_r.blink_hold <= cfg_wdata;
      end else if (cfg_addr == ldsp_pkg::CFG_PRESS_HOLD) begin
        holds_r.press_hold <= cfg_wdata;
      end else if (cfg_addr == ldsp_pkg::CFG_FRAME_HOLD) begin
        holds_r.frame_hold <= cfg_wdata;
      end
    end
  end

  assign full      = q_stat.full;
  assign in_accept = push && !q_stat.full;
  assign empty     = !out_valid;
  assign out_take  = pop && out_valid;

  ldsp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .switch_bits (in_switch_bits),
    .job         (front_job)
  );

  ldsp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_accept),
    .wr_job (front_job),
    .rd_en  (job_done),
    .rd_job (head_job),
    .stat   (q_stat)
  );

  ldsp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job          (head_job),
    .job_valid    (!q_stat.empty),
    .holds        (holds_r),
    .job_done     (job_done),
    .emit         (emit),
    .out_valid    (out_valid),
    .out_take     (out_take),
    .led_pattern  (out_led_pattern),
    .hold_units   (out_hold_units),
    .last_of_pass (out_last_of_pass)
  );

  // No result leaves the back without a queued job
  a_emit_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !q_stat.empty)
    else $error("result emitted with empty job queue");

  // An accepted transaction leaves the queue non-empty next cycle
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !q_stat.empty)
    else $error("accepted transaction not queued");

  // Frame result carries the frame hold, other results do not end the pass
  a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_last_of_pass) |-> (out_hold_units == holds_r.frame_hold))
    else $error("frame result with wrong hold length");

  // A job leaves the queue only on its frame emission
  a_done_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    job_done |=> (!empty && out_last_of_pass))
    else $error("job retired without frame result");

endmodule
